[sv/dbr_pkg.sv]
`default_nettype none
package dbr_pkg;

  // Configuration register indexes
  localparam int unsigned CFG_INDEX_BITS = 1;
  localparam int unsigned CFG_DATA_BITS  = 16;
  localparam logic [CFG_INDEX_BITS-1:0] REG_INTERP_MODE = 1'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SKIP_RATIO  = 1'd1;

  // Interpolation modes (the spare code behaves as bilinear-depth)
  localparam int unsigned MODE_BITS = 2;
  localparam logic [MODE_BITS-1:0] MODE_NEAREST     = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_BILINEAR    = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_BILIN_DEPTH = 2'd2;

  // Skip ratio, Q0.16
  localparam int unsigned RATIO_BITS = 16;
  localparam logic [RATIO_BITS-1:0] RATIO_RESET = 16'd3076;

  // Path status codes
  localparam int unsigned STATUS_BITS = 2;
  localparam logic [STATUS_BITS-1:0] ST_COMPUTED  = 2'd0;
  localparam logic [STATUS_BITS-1:0] ST_INVALID   = 2'd1;
  localparam logic [STATUS_BITS-1:0] ST_ZERO_SKIP = 2'd2;
  localparam logic [STATUS_BITS-1:0] ST_DISC_SKIP = 2'd3;

  // Number of interpolation lanes, one per neighbour
  localparam int unsigned LANES = 4;

  // Per-transaction control carried down the pipe
  typedef struct packed {
    logic entry_valid;
    logic nearest;
    logic check;
  } ctl_t;

endpackage
`default_nettype wire

[sv/dbr_lane.sv]
`default_nettype none
module dbr_lane #(
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  wire logic                                   clk,
  input  wire logic                                   en,
  input  wire logic [FRAC_BITS:0]                     wx,
  input  wire logic [FRAC_BITS:0]                     wy,
  input  wire logic [DEPTH_BITS-1:0]                  depth,
  output logic      [DEPTH_BITS+2*FRAC_BITS:0]        prod,
  output logic                                        zero
);
  localparam int unsigned WB = FRAC_BITS + 1;
  localparam int unsigned WT = 2 * FRAC_BITS + 1;

  logic [2*WB-1:0]       weight_full;
  logic [WT-1:0]         weight;
  logic [DEPTH_BITS-1:0] depth_q;
  logic                  zero_q;
  logic [DEPTH_BITS+WT-1:0] prod_next;

  // Stage 1: neighbour weight, at most 2^(2*FRAC_BITS)
  assign weight_full = wx * wy;

  always_ff @(posedge clk) begin
    if (en) begin
      weight  <= weight_full[WT-1:0];
      depth_q <= depth;
      zero_q  <= (depth == '0);
    end
  end

  // Stage 2: weighted depth
  assign prod_next = depth_q * weight;

  always_ff @(posedge clk) begin
    if (en) begin
      prod <= prod_next;
      zero <= zero_q;
    end
  end

endmodule
`default_nettype wire

[sv/dbr_screen.sv]
`default_nettype none
module dbr_screen #(
  parameter int unsigned DEPTH_BITS = 16
) (
  input  wire logic                              clk,
  input  wire logic                              en,
  input  wire logic [dbr_pkg::RATIO_BITS-1:0]    ratio,
  input  wire logic [DEPTH_BITS-1:0]             d0,
  input  wire logic [DEPTH_BITS-1:0]             d1,
  input  wire logic [DEPTH_BITS-1:0]             d2,
  input  wire logic [DEPTH_BITS-1:0]             d3,
  output logic                                   disc
);
  import dbr_pkg::*;

  localparam int unsigned CW = DEPTH_BITS + RATIO_BITS;

  logic [DEPTH_BITS-1:0] lo_a, lo_b, hi_a, hi_b;
  logic [DEPTH_BITS-1:0] lo_next, hi_next;
  logic [DEPTH_BITS-1:0] lo, hi;
  logic [DEPTH_BITS-1:0] delta;
  logic [CW-1:0]         scaled;

  // Stage 1: min and max of the four neighbours
  always_comb begin
    lo_a    = (d0 < d1) ? d0 : d1;
    lo_b    = (d2 < d3) ? d2 : d3;
    hi_a    = (d0 > d1) ? d0 : d1;
    hi_b    = (d2 > d3) ? d2 : d3;
    lo_next = (lo_a < lo_b) ? lo_a : lo_b;
    hi_next = (hi_a > hi_b) ? hi_a : hi_b;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo <= lo_next;
      hi <= hi_next;
    end
  end

  // Stage 2: spread and ratio times minimum
  always_ff @(posedge clk) begin
    if (en) begin
      delta  <= hi - lo;
      scaled <= ratio * lo;
    end
  end

  // Compare in the merge stage: spread * 2^16 > ratio * min
  assign disc = {delta, {RATIO_BITS{1'b0}}} > scaled;

endmodule
`default_nettype wire

[sv/dbr_merge.sv]
`default_nettype none
module dbr_merge #(
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  wire logic                                  clk,
  input  wire logic                                  en,
  input  wire dbr_pkg::ctl_t                         ctl,
  input  wire logic                                  disc,
  input  wire logic [dbr_pkg::LANES-1:0]             zero,
  input  wire logic [DEPTH_BITS-1:0]                 near_depth,
  input  wire logic [DEPTH_BITS+2*FRAC_BITS:0]       prod [dbr_pkg::LANES],
  output logic      [DEPTH_BITS-1:0]                 depth_out,
  output logic      [dbr_pkg::STATUS_BITS-1:0]       path_status
);
  import dbr_pkg::*;

  localparam int unsigned PW = DEPTH_BITS + 2 * FRAC_BITS + 1;
  localparam logic [PW-1:0] HALF = PW'(1) << (2 * FRAC_BITS - 1);

  logic [PW-1:0]          acc;
  logic [DEPTH_BITS-1:0]  interp;
  logic [DEPTH_BITS-1:0]  depth_next;
  logic [STATUS_BITS-1:0] status_next;

  // Sum of the lanes with round half up; never exceeds the largest depth
  assign acc    = prod[0] + prod[1] + prod[2] + prod[3] + HALF;
  assign interp = acc[2*FRAC_BITS +: DEPTH_BITS];

  // Path selection
  always_comb begin
    priority if (!ctl.entry_valid) begin
      depth_next  = '0;
      status_next = ST_INVALID;
    end else if (ctl.nearest) begin
      depth_next  = near_depth;
      status_next = ST_COMPUTED;
    end else if (ctl.check && (|zero)) begin
      depth_next  = '0;
      status_next = ST_ZERO_SKIP;
    end else if (ctl.check && disc) begin
      depth_next  = '0;
      status_next = ST_DISC_SKIP;
    end else begin
      depth_next  = interp;
      status_next = ST_COMPUTED;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (en) begin
      depth_out   <= depth_next;
      path_status <= status_next;
    end
  end

endmodule
`default_nettype wire

[sv/depth_bilinear_remap_pixel.sv]
// Each accepted input passes lane stage 1, lane stage 2 and the merge output register.
// Throughput: one pixel per cycle; four weight/multiply lanes run in parallel and a
// merge stage sums them, so the pipe never waits on itself.
// The whole pipe holds while a result waits and out_stall is high.
// Reset (rst, synchronous) empties the pipe and sets interp_mode to 0 and skip_ratio to 3076.
`default_nettype none
module depth_bilinear_remap_pixel #(
  parameter int unsigned FRAC_BITS  = 12,
  parameter int unsigned DEPTH_BITS = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration
  input  wire logic                                cfg_wr,
  input  wire logic [dbr_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
  input  wire logic [dbr_pkg::CFG_DATA_BITS-1:0]   cfg_data,
  // input channel
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                entry_valid,
  input  wire logic [FRAC_BITS-1:0]                frac_x,
  input  wire logic [FRAC_BITS-1:0]                frac_y,
  input  wire logic [DEPTH_BITS-1:0]               depth_top_left,
  input  wire logic [DEPTH_BITS-1:0]               depth_top_right,
  input  wire logic [DEPTH_BITS-1:0]               depth_bottom_left,
  input  wire logic [DEPTH_BITS-1:0]               depth_bottom_right,
  // output channel
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic [DEPTH_BITS-1:0]                    depth_out,
  output logic [dbr_pkg::STATUS_BITS-1:0]          path_status
);
  import dbr_pkg::*;

  localparam int unsigned PW = DEPTH_BITS + 2 * FRAC_BITS + 1;
  localparam logic [FRAC_BITS:0] UNIT = (FRAC_BITS+1)'(1) << FRAC_BITS;

  logic [MODE_BITS-1:0]  interp_mode;
  logic [RATIO_BITS-1:0] skip_ratio;

  logic                  en;
  logic                  v1, v2;
  ctl_t                  ctl_next, ctl1, ctl2;
  logic [DEPTH_BITS-1:0] near1, near2;

  logic [FRAC_BITS:0]    fx, fy, ifx, ify;
  logic [DEPTH_BITS-1:0] depth_in [LANES];
  logic [PW-1:0]         prod [LANES];
  logic [LANES-1:0]      zero;
  logic                  disc;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      interp_mode <= MODE_NEAREST;
      skip_ratio  <= RATIO_RESET;
    end else if (cfg_wr) begin
      unique case (cfg_index)
        REG_INTERP_MODE: interp_mode <= cfg_data[MODE_BITS-1:0];
        REG_SKIP_RATIO:  skip_ratio  <= cfg_data[RATIO_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Pipe advances unless a finished result is held by the sink
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      out_valid <= v2;
    end
  end

  // Mode decode per transaction
  always_comb begin
    ctl_next.entry_valid = entry_valid;
    ctl_next.nearest     = (interp_mode == MODE_NEAREST);
    ctl_next.check       = (interp_mode != MODE_NEAREST) && (interp_mode != MODE_BILINEAR);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ctl1  <= ctl_next;
      ctl2  <= ctl1;
      near1 <= depth_top_left;
      near2 <= near1;
    end
  end

  // Offsets and their complements
  assign fx  = {1'b0, frac_x};
  assign fy  = {1'b0, frac_y};
  assign ifx = UNIT - fx;
  assign ify = UNIT - fy;

  assign depth_in[0] = depth_top_left;
  assign depth_in[1] = depth_top_right;
  assign depth_in[2] = depth_bottom_left;
  assign depth_in[3] = depth_bottom_right;

  // One lane per neighbour: bit 0 picks x offset, bit 1 picks y offset
  for (genvar g = 0; g < LANES; g++) begin : g_lane
    dbr_lane #(
      .FRAC_BITS  (FRAC_BITS),
      .DEPTH_BITS (DEPTH_BITS)
    ) u_lane (
      .clk   (clk),
      .en    (en),
      .wx    (((g % 2) == 1) ? fx : ifx),
      .wy    (((g / 2) == 1) ? fy : ify),
      .depth (depth_in[g]),
      .prod  (prod[g]),
      .zero  (zero[g])
    );
  end

  // Discontinuity screen
  dbr_screen #(
    .DEPTH_BITS (DEPTH_BITS)
  ) u_screen (
    .clk   (clk),
    .en    (en),
    .ratio (skip_ratio),
    .d0    (depth_top_left),
    .d1    (depth_top_right),
    .d2    (depth_bottom_left),
    .d3    (depth_bottom_right),
    .disc  (disc)
  );

  // Merge and output register
  dbr_merge #(
    .FRAC_BITS  (FRAC_BITS),
    .DEPTH_BITS (DEPTH_BITS)
  ) u_merge (
    .clk         (clk),
    .en          (en),
    .ctl         (ctl2),
    .disc        (disc),
    .zero        (zero),
    .near_depth  (near2),
    .prod        (prod),
    .depth_out   (depth_out),
    .path_status (path_status)
  );

endmodule
`default_nettype wire

[tb/tb_depth_bilinear_remap_pixel.sv]
`timescale 1ns / 1ps
module tb_depth_bilinear_remap_pixel;
  import dbr_pkg::*;

  localparam int unsigned FRAC_W       = 12;
  localparam int unsigned DEPTH_W      = 16;
  localparam int unsigned PIPE_LATENCY = 3;
  localparam int unsigned CYCLE_LIMIT  = 200000;
  localparam int unsigned NUM_PHASES   = 8;
  localparam int unsigned PHASE_ITEMS  = 137;
  localparam int unsigned NUM_DIRECTED = 25;
  // spare mode code, decoded by the block as bilinear-depth
  localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;

  typedef struct packed {
    logic               ev;
    logic [FRAC_W-1:0]  fx;
    logic [FRAC_W-1:0]  fy;
    logic [DEPTH_W-1:0] tl;
    logic [DEPTH_W-1:0] tr;
    logic [DEPTH_W-1:0] bl;
    logic [DEPTH_W-1:0] br;
  } remap_entry_t;

  typedef struct packed {
    logic [DEPTH_W-1:0]     depth;
    logic [STATUS_BITS-1:0] status;
  } depth_result_t;

  // directed row: register settings, the entry, and a hand-written result where obvious
  typedef struct packed {
    logic [MODE_BITS-1:0]   mode;
    logic [RATIO_BITS-1:0]  ratio;
    remap_entry_t           entry;
    logic                   typed;
    depth_result_t          res;
  } directed_row_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_wr;
  logic [CFG_INDEX_BITS-1:0] cfg_index;
  logic [CFG_DATA_BITS-1:0]  cfg_data;
  logic                      in_valid;
  logic                      in_stall;
  logic                      entry_valid;
  logic [FRAC_W-1:0]         frac_x;
  logic [FRAC_W-1:0]         frac_y;
  logic [DEPTH_W-1:0]        depth_top_left;
  logic [DEPTH_W-1:0]        depth_top_right;
  logic [DEPTH_W-1:0]        depth_bottom_left;
  logic [DEPTH_W-1:0]        depth_bottom_right;
  logic                      out_valid;
  logic                      out_stall;
  logic [DEPTH_W-1:0]        depth_out;
  logic [STATUS_BITS-1:0]    path_status;

  // local copy of the register file
  logic [MODE_BITS-1:0]  mode_now  = MODE_NEAREST;
  logic [RATIO_BITS-1:0] ratio_now = RATIO_RESET;

  depth_result_t expected_pixels[$];
  int unsigned   mismatches = 0;
  int unsigned   cycles = 0;
  int unsigned   results_seen = 0;
  int unsigned   calm_left = 0;
  logic          quiet = 1'b0;
  int unsigned   stall_left = 0;
  int unsigned   free_left = 0;

  depth_bilinear_remap_pixel dut (
    .clk                (clk),
    .rst                (rst),
    .cfg_wr             (cfg_wr),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .entry_valid        (entry_valid),
    .frac_x             (frac_x),
    .frac_y             (frac_y),
    .depth_top_left     (depth_top_left),
    .depth_top_right    (depth_top_right),
    .depth_bottom_left  (depth_bottom_left),
    .depth_bottom_right (depth_bottom_right),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .depth_out          (depth_out),
    .path_status        (path_status)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Directed stimulus; reset values of both registers are used by the first rows
  directed_row_t directed_rows [0:NUM_DIRECTED-1] = '{
    '{MODE_NEAREST, RATIO_RESET, '{1'b1, 12'd4095, 12'd4095, 16'd1234, 16'hFFFF, 16'hFFFF,
      16'hFFFF}, 1'b1, '{16'd1234, ST_COMPUTED}},
    '{MODE_NEAREST, RATIO_RESET, '{1'b1, 12'd0, 12'd0, 16'hFFFF, 16'd0, 16'd0, 16'd0},
      1'b1, '{16'hFFFF, ST_COMPUTED}},
    '{MODE_NEAREST, RATIO_RESET, '{1'b1, 12'd2048, 12'd1, 16'd0, 16'hFFFF, 16'd1, 16'hFFFF},
      1'b1, '{16'd0, ST_COMPUTED}},
    '{MODE_NEAREST, RATIO_RESET, '{1'b0, 12'd0, 12'd0, 16'd500, 16'd500, 16'd500, 16'd500},
      1'b1, '{16'd0, ST_INVALID}},
    // spread just under and just over the reset ratio
    '{MODE_BILIN_DEPTH, RATIO_RESET, '{1'b1, 12'd0, 12'd0, 16'd1000, 16'd1046, 16'd1000,
      16'd1000}, 1'b0, '0},
    '{MODE_BILIN_DEPTH, RATIO_RESET, '{1'b1, 12'd0, 12'd0, 16'd1000, 16'd1047, 16'd1000,
      16'd1000}, 1'b1, '{16'd0, ST_DISC_SKIP}},
    '{MODE_BILINEAR, RATIO_RESET, '{1'b1, 12'd0, 12'd0, 16'd1000, 16'd60000, 16'd60000,
      16'd60000}, 1'b1, '{16'd1000, ST_COMPUTED}},
    '{MODE_BILINEAR, RATIO_RESET, '{1'b1, 12'd4095, 12'd4095, 16'd0, 16'd0, 16'd0, 16'hFFFF},
      1'b0, '0},
    '{MODE_BILINEAR, RATIO_RESET, '{1'b1, 12'd4095, 12'd0, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF}, 1'b1, '{16'hFFFF, ST_COMPUTED}},
    '{MODE_BILINEAR, RATIO_RESET, '{1'b1, 12'd2048, 12'd2048, 16'd1, 16'd2, 16'd3, 16'd4},
      1'b0, '0},
    // exact half, rounds up
    '{MODE_BILINEAR, RATIO_RESET, '{1'b1, 12'd2048, 12'd0, 16'd0, 16'd1, 16'd7, 16'd7},
      1'b0, '0},
    '{MODE_BILINEAR, RATIO_RESET, '{1'b1, 12'd1, 12'd4095, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF},
      1'b0, '0},
    '{MODE_BILINEAR, RATIO_RESET, '{1'b0, 12'd4095, 12'd4095, 16'hFFFF, 16'hFFFF, 16'hFFFF,
      16'hFFFF}, 1'b1, '{16'd0, ST_INVALID}},
    '{MODE_BILIN_DEPTH, RATIO_RESET, '{1'b1, 12'd100, 12'd200, 16'd5000, 16'd5000, 16'd0,
      16'd5000}, 1'b1, '{16'd0, ST_ZERO_SKIP}},
    '{MODE_BILIN_DEPTH, RATIO_RESET, '{1'b1, 12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      1'b1, '{16'd0, ST_ZERO_SKIP}},
    '{MODE_BILIN_DEPTH, RATIO_RESET, '{1'b0, 12'd0, 12'd0, 16'd0, 16'd0, 16'd0, 16'd0},
      1'b1, '{16'd0, ST_INVALID}},
    '{MODE_BILIN_DEPTH, RATIO_RESET, '{1'b1, 12'd1234, 12'd3000, 16'd1000, 16'd1000,
      16'd1000, 16'd1000}, 1'b1, '{16'd1000, ST_COMPUTED}},
    '{MODE_BILIN_DEPTH, RATIO_RESET, '{1'b1, 12'd0, 12'd0, 16'd1, 16'hFFFF, 16'hFFFF,
      16'hFFFF}, 1'b1, '{16'd0, ST_DISC_SKIP}},
    '{MODE_SPARE, RATIO_RESET, '{1'b1, 12'd0, 12'd0, 16'd1000, 16'd1047, 16'd1000, 16'd1000},
      1'b1, '{16'd0, ST_DISC_SKIP}},
    '{MODE_SPARE, RATIO_RESET, '{1'b1, 12'd4095, 12'd4095, 16'd5000, 16'd5000, 16'd5000,
      16'd0}, 1'b1, '{16'd0, ST_ZERO_SKIP}},
    '{MODE_SPARE, RATIO_RESET, '{1'b1, 12'd2000, 12'd3000, 16'd1000, 16'd1040, 16'd1020,
      16'd1010}, 1'b0, '0},
    // zero ratio: only a flat neighbourhood survives
    '{MODE_BILIN_DEPTH, 16'd0, '{1'b1, 12'd0, 12'd0, 16'd5000, 16'd5000, 16'd5000, 16'd5000},
      1'b1, '{16'd5000, ST_COMPUTED}},
    '{MODE_BILIN_DEPTH, 16'd0, '{1'b1, 12'd0, 12'd0, 16'd5000, 16'd5001, 16'd5000, 16'd5000},
      1'b1, '{16'd0, ST_DISC_SKIP}},
    '{MODE_BILIN_DEPTH, 16'hFFFF, '{1'b1, 12'd0, 12'd0, 16'd1, 16'd2, 16'd2, 16'd2},
      1'b0, '0},
    '{MODE_BILIN_DEPTH, 16'hFFFF, '{1'b1, 12'd4095, 12'd0, 16'd100, 16'd199, 16'd150,
      16'd120}, 1'b0, '0}
  };

  // Expected pixel for one entry under the current register settings
  function automatic depth_result_t predict_pixel(remap_entry_t e);
    depth_result_t     r;
    longint unsigned   d0, d1, d2, d3, lo, hi, fx, fy, ifx, ify, acc;
    r.depth  = '0;
    r.status = ST_COMPUTED;
    d0 = e.tl;
    d1 = e.tr;
    d2 = e.bl;
    d3 = e.br;
    if (!e.ev) begin
      r.status = ST_INVALID;
      return r;
    end
    if (mode_now == MODE_NEAREST) begin
      r.depth = e.tl;
      return r;
    end
    // bilinear-depth and the spare code screen the neighbourhood first
    if (mode_now != MODE_BILINEAR) begin
      if (d0 == 0 || d1 == 0 || d2 == 0 || d3 == 0) begin
        r.status = ST_ZERO_SKIP;
        return r;
      end
      lo = d0;
      hi = d0;
      if (d1 < lo) lo = d1;
      if (d2 < lo) lo = d2;
      if (d3 < lo) lo = d3;
      if (d1 > hi) hi = d1;
      if (d2 > hi) hi = d2;
      if (d3 > hi) hi = d3;
      if (((hi - lo) << 16) > longint'(ratio_now) * lo) begin
        r.status = ST_DISC_SKIP;
        return r;
      end
    end
    fx  = e.fx;
    fy  = e.fy;
    ifx = (64'd1 << FRAC_W) - fx;
    ify = (64'd1 << FRAC_W) - fy;
    acc = d0 * (ifx * ify) + d1 * (fx * ify) + d2 * (ifx * fy) + d3 * (fx * fy);
    acc = (acc + (64'd1 << (2 * FRAC_W - 1))) >> (2 * FRAC_W);
    r.depth = acc[DEPTH_W-1:0];
    return r;
  endfunction

  function automatic logic [DEPTH_W-1:0] near_depth(longint unsigned base,
                                                    longint unsigned span);
    longint unsigned v;
    v = base + $urandom_range(0, int'(span));
    if (v > 65535) v = 65535;
    return v[DEPTH_W-1:0];
  endfunction

  function automatic logic [FRAC_W-1:0] random_frac();
    if ($urandom_range(0, 7) == 0) return $urandom_range(0, 1) ? '1 : '0;
    return FRAC_W'($urandom);
  endfunction

  // Mostly neighbourhoods whose spread sits around the skip threshold, plus noise
  function automatic remap_entry_t random_entry();
    remap_entry_t    e;
    int unsigned     kind;
    longint unsigned base, span;
    kind = $urandom_range(0, 19);
    base = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 300) : $urandom_range(1, 65535);
    span = (base * longint'(ratio_now)) >> 16;
    span = span + span / 2 + 2;
    e.ev = (kind != 0);
    e.fx = random_frac();
    e.fy = random_frac();
    e.tl = near_depth(base, span);
    e.tr = near_depth(base, span);
    e.bl = near_depth(base, span);
    e.br = near_depth(base, span);
    case (kind)
      1, 2: begin
        case ($urandom_range(0, 3))
          0: e.tl = '0;
          1: e.tr = '0;
          2: e.bl = '0;
          default: e.br = '0;
        endcase
      end
      3: begin
        e.tl = DEPTH_W'($urandom);
        e.tr = DEPTH_W'($urandom);
        e.bl = DEPTH_W'($urandom);
        e.br = DEPTH_W'($urandom);
      end
      4: begin
        e.tl = $urandom_range(0, 1) ? '1 : DEPTH_W'($urandom_range(0, 3));
        e.tr = $urandom_range(0, 1) ? '1 : DEPTH_W'($urandom_range(0, 3));
        e.bl = $urandom_range(0, 1) ? '1 : DEPTH_W'($urandom_range(0, 3));
        e.br = $urandom_range(0, 1) ? '1 : DEPTH_W'($urandom_range(0, 3));
      end
      default: ;
    endcase
    return e;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Present one entry, hold it until taken, then queue its expected pixel
  task automatic send_entry(input remap_entry_t e, input logic typed,
                            input depth_result_t typed_res);
    if (!quiet && calm_left == 0 && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    if (calm_left > 0) calm_left--;
    else if ($urandom_range(0, 40) == 0) calm_left = 40;
    in_valid           <= 1'b1;
    entry_valid        <= e.ev;
    frac_x             <= e.fx;
    frac_y             <= e.fy;
    depth_top_left     <= e.tl;
    depth_top_right    <= e.tr;
    depth_bottom_left  <= e.bl;
    depth_bottom_right <= e.br;
    do @(posedge clk); while (in_stall);
    expected_pixels.push_back(typed ? typed_res : predict_pixel(e));
  endtask

  // Stop sending and wait until every queued pixel has come back
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_pixels.size() != 0) @(posedge clk);
    repeat (PIPE_LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] val);
    cfg_wr    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    if (idx == REG_INTERP_MODE) mode_now = val[MODE_BITS-1:0];
    else ratio_now = val[RATIO_BITS-1:0];
    cfg_wr <= 1'b0;
    @(posedge clk);
  endtask

  // Receiver: random stall bursts, mostly with free stretches between
  always @(posedge clk) begin
    if (rst || quiet) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
      free_left  <= 0;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= 1'b1;
    end else if (free_left != 0) begin
      free_left <= free_left - 1;
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 4) == 0) begin
      free_left <= $urandom_range(20, 60);
      out_stall <= 1'b0;
    end else begin
      stall_left <= $urandom_range(0, 4);
      free_left  <= $urandom_range(0, 6);
      out_stall  <= 1'b1;
    end
  end

  // Result checker: each output transaction against the oldest expected pixel
  always @(posedge clk) begin : check_results
    depth_result_t want;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (expected_pixels.size() == 0) begin
        report_mismatch($sformatf("result %0d with none pending: depth %0d status %0d",
                                  results_seen, depth_out, path_status));
      end else begin
        want = expected_pixels.pop_front();
        if (depth_out !== want.depth)
          report_mismatch($sformatf("result %0d depth_out %0d, want %0d",
                                    results_seen, depth_out, want.depth));
        if (path_status !== want.status)
          report_mismatch($sformatf("result %0d path_status %0d, want %0d",
                                    results_seen, path_status, want.status));
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    directed_row_t         row;
    logic [MODE_BITS-1:0]  phase_modes [0:NUM_PHASES-1];
    logic [RATIO_BITS-1:0] phase_ratios [0:NUM_PHASES-1];
    phase_modes  = '{MODE_BILIN_DEPTH, MODE_BILINEAR, MODE_SPARE, MODE_NEAREST,
                     MODE_BILIN_DEPTH, MODE_SPARE, MODE_BILINEAR, MODE_BILIN_DEPTH};
    phase_ratios = '{RATIO_BITS'($urandom), 16'd0, 16'hFFFF, RATIO_RESET,
                     16'd0, RATIO_BITS'($urandom), RATIO_BITS'($urandom), 16'hFFFF};
    cfg_wr             <= 1'b0;
    cfg_index          <= '0;
    cfg_data           <= '0;
    in_valid           <= 1'b0;
    entry_valid        <= 1'b0;
    frac_x             <= '0;
    frac_y             <= '0;
    depth_top_left     <= '0;
    depth_top_right    <= '0;
    depth_bottom_left  <= '0;
    depth_bottom_right <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part: registers change only between rows that need it
    for (int i = 0; i < NUM_DIRECTED; i++) begin
      row = directed_rows[i];
      if (row.mode != mode_now || row.ratio != ratio_now) begin
        wait_idle();
        if (row.mode != mode_now) write_reg(REG_INTERP_MODE, CFG_DATA_BITS'(row.mode));
        if (row.ratio != ratio_now) write_reg(REG_SKIP_RATIO, row.ratio);
      end
      send_entry(row.entry, row.typed, row.res);
    end

    // random phases, each under its own register settings; the last runs flat out
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      if (p == NUM_PHASES - 1) quiet <= 1'b1;
      write_reg(REG_INTERP_MODE, {14'($urandom), phase_modes[p]});
      write_reg(REG_SKIP_RATIO, phase_ratios[p]);
      for (int n = 0; n < PHASE_ITEMS; n++)
        send_entry(random_entry(), 1'b0, '0);
    end

    wait_idle();
    repeat (2 * PIPE_LATENCY) @(posedge clk);
    if (mismatches == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

[depth_bilinear_remap_pixel.f]
sv/dbr_pkg.sv
sv/dbr_lane.sv
sv/dbr_screen.sv
sv/dbr_merge.sv
sv/depth_bilinear_remap_pixel.sv
tb/tb_depth_bilinear_remap_pixel.sv
